[rtl/core/akm_pkg.sv]
package akm_pkg;

  localparam int CH_W  = 8;
  localparam int POS_W = 4;
  localparam int NUM_W = 4;

  localparam logic [CH_W-1:0] CASE_BIT  = 8'h20;
  localparam logic [CH_W-1:0] CHAR_A    = 8'h41;
  localparam logic [CH_W-1:0] CHAR_DOT  = 8'h2E;
  localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};

  localparam int KW_ROWS = 9;
  localparam int KW_COLS = 8;

  localparam logic [CH_W-1:0] KW_TABLE [KW_ROWS][KW_COLS] = '{
    '{"B", "A", "S", "I", "C", 8'h00, 8'h00, 8'h00},
    '{"C", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "I", "S", "M", "O", "U", "N", "T"},
    '{"F", "X", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", "E", "L", "P", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"M", "O", "U", "N", "T", 8'h00, 8'h00, 8'h00},
    '{"M", "O", "U", "N", "T", "S", 8'h00, 8'h00},
    '{"Q", "U", "I", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"C", "O", "R", "E", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // Byte of keyword e at offset i; rows past the table and bytes past the
  // length limit read as zero.
  function automatic logic [CH_W-1:0] kw_byte(input int e, input int i, input int max_len);
    logic [CH_W-1:0] b;
    b = '0;
    if (e < KW_ROWS && i < KW_COLS && i < max_len) begin
      b = KW_TABLE[e][i];
    end
    return b;
  endfunction

  function automatic int kw_len(input int e, input int max_len);
    int   n;
    logic stop;
    n    = 0;
    stop = 1'b0;
    for (int i = 0; i < 15; i++) begin
      if (!stop && i < max_len && kw_byte(e, i, max_len) != '0) begin
        n++;
      end else begin
        stop = 1'b1;
      end
    end
    return n;
  endfunction

  typedef struct packed {
    logic              proc;   // item leaves the input register this cycle
    logic              start;  // item opens a new line
    logic              active; // line not yet reported: compare this byte
    logic [CH_W-1:0]   ch;
    logic [POS_W-1:0]  pos;
  } akm_step_t;

  typedef struct packed {
    logic              alive;
    logic              hit;
    logic [POS_W-1:0]  len;
  } akm_lane_t;

endpackage

[rtl/core/akm_channels.sv]
interface akm_in_if;
  logic                       valid;
  logic                       ready;
  logic [akm_pkg::CH_W-1:0]   ch;
  logic                       start_req;

  modport source(output valid, ch, start_req, input ready);
  modport sink(input valid, ch, start_req, output ready);
endinterface

interface akm_out_if;
  logic                        valid;
  logic                        ready;
  logic [akm_pkg::NUM_W-1:0]   command_number;
  logic [akm_pkg::POS_W-1:0]   consumed;

  modport source(output valid, command_number, consumed, input ready);
  modport sink(input valid, command_number, consumed, output ready);
endinterface

[rtl/core/akm_match_lane.sv]
module akm_match_lane #(
  parameter int ENTRY   = 0,
  parameter int MAX_LEN = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  akm_pkg::akm_step_t  step,
  output akm_pkg::akm_lane_t  stat
);

  localparam int KW_LEN = akm_pkg::kw_len(ENTRY, MAX_LEN);
  localparam logic KW_PRESENT = (KW_LEN != 0);

  logic [akm_pkg::CH_W-1:0]  kw_bytes [MAX_LEN];
  logic [akm_pkg::CH_W-1:0]  kb;
  logic                      alive_r, alive_nxt;
  logic                      hit_r, hit_nxt;
  logic [akm_pkg::POS_W-1:0] len_r, len_nxt;
  logic                      dot, below_a, match;
  logic [akm_pkg::POS_W:0]   len_sum;

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_kw
    assign kw_bytes[g] = akm_pkg::kw_byte(ENTRY, g, MAX_LEN);
  end

  always_comb begin
    kb = '0;
    for (int i = 0; i < MAX_LEN; i++) begin
      if (step.pos == akm_pkg::POS_W'(i)) begin
        kb = kw_bytes[i];
      end
    end
  end

  assign dot     = (step.ch == akm_pkg::CHAR_DOT);
  // bytes with the top bit set sort below 'A', as signed characters do
  assign below_a = (step.ch < akm_pkg::CHAR_A) || step.ch[akm_pkg::CH_W-1];
  assign match   = (step.pos < akm_pkg::POS_W'(KW_LEN)) &&
                   ((step.ch == kb) || ((step.ch ^ akm_pkg::CASE_BIT) == kb));
  assign len_sum = {1'b0, step.pos} + {{akm_pkg::POS_W{1'b0}}, dot};

  always_comb begin
    alive_nxt = step.start ? KW_PRESENT : alive_r;
    hit_nxt   = step.start ? 1'b0 : hit_r;
    len_nxt   = step.start ? '0 : len_r;
    if (step.active && alive_nxt && !match) begin
      // decide the entry at the first byte that breaks its keyword
      alive_nxt = 1'b0;
      hit_nxt   = dot || ((step.pos == akm_pkg::POS_W'(KW_LEN)) && below_a);
      len_nxt   = len_sum[akm_pkg::POS_W] ? akm_pkg::POS_MAX
                                          : len_sum[akm_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= KW_PRESENT;
      hit_r   <= 1'b0;
      len_r   <= '0;
    end else if (step.proc) begin
      alive_r <= alive_nxt;
      hit_r   <= hit_nxt;
      len_r   <= len_nxt;
    end
  end

  assign stat.alive = alive_nxt;
  assign stat.hit   = hit_nxt;
  assign stat.len   = len_nxt;

endmodule

[rtl/core/akm_result_pick.sv]
module akm_result_pick #(
  parameter int NUM_ENTRIES = 9
) (
  input  akm_pkg::akm_lane_t          lanes [NUM_ENTRIES],
  output logic                        any_alive,
  output logic [akm_pkg::NUM_W-1:0]   command_number,
  output logic [akm_pkg::POS_W-1:0]   consumed
);

  always_comb begin
    any_alive      = 1'b0;
    command_number = '0;
    consumed       = '0;
    // walk from the top so the lowest hit entry wins
    for (int e = NUM_ENTRIES - 1; e >= 0; e--) begin
      any_alive = any_alive | lanes[e].alive;
      if (lanes[e].hit) begin
        command_number = akm_pkg::NUM_W'(e + 1);
        consumed       = lanes[e].len;
      end
    end
  end

endmodule

[rtl/core/abbreviated_keyword_matcher.sv]
// out_bus.valid rises once the deciding byte has passed the input register, then the
// result register. Throughput: one byte per cycle unless out_bus stalls; every table
// entry is compared in parallel in its lane.
// Reset (rst_n low, synchronous): pipeline empty, match state cleared, ready for a new
// line, so the first byte after reset starts one even without start_req.
module abbreviated_keyword_matcher #(
  parameter int NUM_ENTRIES = 9,
  parameter int MAX_LEN     = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  akm_in_if.sink     in_bus,
  akm_out_if.source  out_bus
);

  logic                        s1_valid_r, s1_valid_nxt;
  logic [akm_pkg::CH_W-1:0]    s1_ch_r;
  logic                        s1_start_r;
  logic [akm_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                        reported_r, reported_nxt;
  logic                        out_valid_r;
  logic [akm_pkg::NUM_W-1:0]   out_cmd_r;
  logic [akm_pkg::POS_W-1:0]   out_cons_r;

  logic                        out_free, proc, in_xfer, emit;
  logic                        reported_eff;
  logic [akm_pkg::POS_W-1:0]   pos_eff;
  akm_pkg::akm_step_t          step;
  akm_pkg::akm_lane_t          lanes [NUM_ENTRIES];
  logic                        any_alive;
  logic [akm_pkg::NUM_W-1:0]   pick_cmd;
  logic [akm_pkg::POS_W-1:0]   pick_cons;

  assign out_free     = !out_valid_r || out_bus.ready;
  assign proc         = s1_valid_r && out_free;
  assign in_bus.ready = !s1_valid_r || out_free;
  assign in_xfer      = in_bus.valid && in_bus.ready;

  // a start byte clears the line state before it is compared
  assign reported_eff = s1_start_r ? 1'b0 : reported_r;
  assign pos_eff      = s1_start_r ? '0 : pos_r;

  assign step.proc   = proc;
  assign step.start  = s1_start_r;
  assign step.active = proc && !reported_eff;
  assign step.ch     = s1_ch_r;
  assign step.pos    = pos_eff;

  for (genvar e = 0; e < NUM_ENTRIES; e++) begin : g_lane
    akm_match_lane #(
      .ENTRY   (e),
      .MAX_LEN (MAX_LEN)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (step),
      .stat  (lanes[e])
    );
  end

  akm_result_pick #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_pick (
    .lanes          (lanes),
    .any_alive      (any_alive),
    .command_number (pick_cmd),
    .consumed       (pick_cons)
  );

  assign emit = step.active && !any_alive;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (proc) begin
      s1_valid_nxt = 1'b0;
    end
    pos_nxt      = pos_r;
    reported_nxt = reported_r;
    if (proc) begin
      pos_nxt      = (step.active && pos_eff != akm_pkg::POS_MAX) ? pos_eff + 1'b1 : pos_eff;
      reported_nxt = reported_eff || emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pos_r       <= '0;
      reported_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      pos_r      <= pos_nxt;
      reported_r <= reported_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ch_r    <= in_bus.ch;
      s1_start_r <= in_bus.start_req;
    end
    if (emit) begin
      out_cmd_r  <= pick_cmd;
      out_cons_r <= pick_cons;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.command_number = out_cmd_r;
  assign out_bus.consumed       = out_cons_r;

  a_report_marks: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> reported_r)
    else $error("line not marked reported after its result");

  a_one_per_line: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && reported_r && !s1_start_r) |-> !emit)
    else $error("second result for one command line");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !proc) |=> (s1_valid_r && $stable(s1_ch_r) && $stable(s1_start_r)))
    else $error("pending byte lost from input register");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_cmd_r == '0) |-> (out_cons_r == '0))
    else $error("no-hit result with nonzero length");

  a_hit_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_cmd_r != '0) |-> (out_cons_r != '0))
    else $error("hit result with zero length");

endmodule
